FILE: rtl/core/csbag_pkg.sv
// Shared types and constants for the clipped stretch-blit address generator.
`timescale 1ns / 1ps
`default_nettype none
package csbag_pkg;

	localparam int ACC_W = 14;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	localparam logic [1:0] KIND_START_OK  = 2'd0;
	localparam logic [1:0] KIND_REJECT    = 2'd1;
	localparam logic [1:0] KIND_PIXEL     = 2'd2;
	localparam logic [1:0] KIND_IDLE_STEP = 2'd3;

	typedef enum logic {
		ALU_SUB,
		ALU_ADD
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_H_CMP,
		ST_H_ADD,
		ST_V_CMP,
		ST_V_ADD,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [11:0] dx;
		logic signed [11:0] dy;
		logic [10:0]        dw;
		logic [10:0]        dh;
		logic [10:0]        sl;
		logic [10:0]        st;
		logic [10:0]        sr;
		logic [10:0]        sb;
		logic [10:0]        bw;
		logic [10:0]        bh;
	} desc_t;

	typedef struct packed {
		logic signed [11:0] left;
		logic signed [11:0] top;
		logic signed [11:0] right;
		logic signed [11:0] bottom;
	} clip_t;

	typedef struct packed {
		logic        reject;
		clip_t       clip;
		logic [10:0] src_w;
		logic [10:0] src_h;
	} chk_t;

endpackage
`default_nettype wire

FILE: rtl/core/csbag_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module csbag_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/csbag_alu.sv
// Shared add/subtract unit with greater-than compare for the DDA steppers.
`timescale 1ns / 1ps
`default_nettype none
module csbag_alu (
	input  wire csbag_pkg::alu_op_t             op,
	input  wire logic [csbag_pkg::ACC_W-1:0]    a,
	input  wire logic [csbag_pkg::ACC_W-1:0]    b,
	output logic      [csbag_pkg::ACC_W-1:0]    res,
	output logic                                gt
);
	import csbag_pkg::*;

	logic [ACC_W:0] diff;

	always_comb begin
		diff = {1'b0, a} - {1'b0, b};
		gt   = !diff[ACC_W] && (diff[ACC_W-1:0] != '0);
		if (op == ALU_ADD) begin
			res = a + b;
		end else begin
			res = diff[ACC_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/csbag_check.sv
// Descriptor validation and destination clipping against the screen.
`timescale 1ns / 1ps
`default_nettype none
module csbag_check #(
	parameter int MAX_SCREEN_WIDTH = 1024,
	parameter int MAX_BITMAP_SIZE  = 1024
) (
	input  wire csbag_pkg::desc_t desc,
	input  wire logic [10:0]      screen_w,
	input  wire logic [10:0]      screen_h,
	output csbag_pkg::chk_t       chk
);
	import csbag_pkg::*;

	localparam logic signed [13:0] MAXS = 14'(MAX_SCREEN_WIDTH);
	localparam logic signed [13:0] MAXB = 14'(MAX_BITMAP_SIZE);

	logic signed [13:0] sw, sh, dx, dy, dw, dh, sl, st, sr, sb, bw, bh;
	logic signed [13:0] ex, ey, rf, bf, rc, bc;

	always_comb begin
		dx = signed'({{2{desc.dx[11]}}, desc.dx});
		dy = signed'({{2{desc.dy[11]}}, desc.dy});
		dw = signed'({3'b000, desc.dw});
		dh = signed'({3'b000, desc.dh});
		sl = signed'({3'b000, desc.sl});
		st = signed'({3'b000, desc.st});
		sr = signed'({3'b000, desc.sr});
		sb = signed'({3'b000, desc.sb});
		bw = signed'({3'b000, desc.bw});
		bh = signed'({3'b000, desc.bh});

		if (screen_w == '0) begin
			sw = 14'sd1;
		end else if (signed'({3'b000, screen_w}) > MAXS) begin
			sw = MAXS;
		end else begin
			sw = signed'({3'b000, screen_w});
		end
		if (screen_h == '0) begin
			sh = 14'sd1;
		end else if (signed'({3'b000, screen_h}) > MAXS) begin
			sh = MAXS;
		end else begin
			sh = signed'({3'b000, screen_h});
		end

		ex = dx + dw;
		ey = dy + dh;
		rf = ex - 14'sd1;
		bf = ey - 14'sd1;
		rc = (rf >= sw) ? sw - 14'sd1 : rf;
		bc = (bf >= sh) ? sh - 14'sd1 : bf;

		chk.reject = (dw < 14'sd1) || (dh < 14'sd1) || (sl >= sr) || (st >= sb) ||
			(bw > MAXB) || (bh > MAXB) || (sr > bw) || (sb > bh) ||
			(dx >= sw) || (dy >= sh) || (ex <= 14'sd0) || (ey <= 14'sd0);
		chk.clip.left   = dx[13] ? 12'sd0 : desc.dx;
		chk.clip.top    = dy[13] ? 12'sd0 : desc.dy;
		chk.clip.right  = rc[11:0];
		chk.clip.bottom = bc[11:0];
		chk.src_w       = desc.sr - desc.sl;
		chk.src_h       = desc.sb - desc.st;
	end

endmodule
`default_nettype wire

FILE: rtl/core/clipped_stretch_blit_address_gen.sv
// Top level of the clipped stretch-blit address generator: sequencer and registers; reset clears
// control only. Pixel steps answer via ST_RD and ST_EMIT, rejected starts via ST_CHECK, ST_EMIT,
// idle steps via ST_EMIT; the next transaction is taken back in ST_IDLE. A pixel ending a row
// first runs ST_V_ADD, then ST_V_CMP per source row advanced. A start is answered after ST_CHECK,
// ST_H_CMP/ST_H_ADD from the unclipped left to the clipped right edge and ST_V_CMP/ST_V_ADD
// over rows above the first visible row, CMPs repeating per source step; a held result stalls.
`timescale 1ns / 1ps
`default_nettype none
module clipped_stretch_blit_address_gen #(
	parameter int MAX_SCREEN_WIDTH = 1024,
	parameter int MAX_BITMAP_SIZE  = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic signed [11:0] dest_x,
	input  wire logic signed [11:0] dest_y,
	input  wire logic [10:0]        dest_w,
	input  wire logic [10:0]        dest_h,
	input  wire logic [10:0]        src_l,
	input  wire logic [10:0]        src_top,
	input  wire logic [10:0]        src_r,
	input  wire logic [10:0]        src_b,
	input  wire logic [10:0]        bmp_w,
	input  wire logic [10:0]        bmp_h,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              kind,
	output logic [9:0]              out_dest_x,
	output logic [9:0]              out_dest_y,
	output logic [9:0]              out_src_x,
	output logic [9:0]              out_src_y,
	output logic                    last
);
	import csbag_pkg::*;

	localparam int AW = $clog2(MAX_SCREEN_WIDTH);

	state_t             state_q, state_d;
	logic               busy_q, mode_start_q, out_valid_q;
	logic [1:0]         kind_q;
	logic [10:0]        screen_w_q, screen_h_q;
	desc_t              desc_q;
	chk_t               chk;
	clip_t              clip_q;
	logic [10:0]        src_w_q, src_h_q;
	logic [ACC_W-1:0]   hacc_q, vacc_q;
	logic [10:0]        px_q, src_row_q, cur_col_q;
	logic signed [11:0] x_q, cur_row_q;

	alu_op_t            alu_op;
	logic [ACC_W-1:0]   alu_a, alu_b, alu_res;
	logic               alu_gt;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_addr;
	logic [9:0]         ram_rdata;
	logic [11:0]        col_ext;

	logic               in_fire, cfg_wr, emit_fire, last_pix, row_end, v_done;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign in_fire   = in_valid && in_ready;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign row_end   = cur_col_q >= clip_q.right[10:0];
	assign last_pix  = row_end && (cur_row_q >= clip_q.bottom);
	assign v_done    = cur_row_q >= clip_q.top;
	assign col_ext   = {1'b0, cur_col_q};
	assign out_valid = out_valid_q;

	always_comb begin
		if (paddr[2]) begin
			prdata = {21'd0, screen_h_q};
		end else begin
			prdata = {21'd0, screen_w_q};
		end
	end

	csbag_check #(
		.MAX_SCREEN_WIDTH(MAX_SCREEN_WIDTH),
		.MAX_BITMAP_SIZE (MAX_BITMAP_SIZE)
	) u_check (
		.desc    (desc_q),
		.screen_w(screen_w_q),
		.screen_h(screen_h_q),
		.chk     (chk)
	);

	csbag_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res),
		.gt (alu_gt)
	);

	csbag_ram #(
		.WIDTH(10),
		.DEPTH(MAX_SCREEN_WIDTH)
	) u_col_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(px_q[9:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (func == FUNC_START) begin
						state_d = ST_CHECK;
					end else if (busy_q) begin
						state_d = ST_RD;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_CHECK: begin
				state_d = chk.reject ? ST_EMIT : ST_H_CMP;
			end
			ST_H_CMP: begin
				state_d = alu_gt ? ST_H_CMP : ST_H_ADD;
			end
			ST_H_ADD: begin
				state_d = (x_q == clip_q.right) ? ST_V_CMP : ST_H_CMP;
			end
			ST_V_CMP: begin
				if (alu_gt) begin
					state_d = ST_V_CMP;
				end else if (!v_done) begin
					state_d = ST_V_ADD;
				end else if (mode_start_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_V_ADD: begin
				state_d = ST_V_CMP;
			end
			ST_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire) begin
					if (kind_q == KIND_PIXEL && !last_pix && row_end) begin
						state_d = ST_V_ADD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		alu_op   = ALU_SUB;
		alu_a    = hacc_q;
		alu_b    = '0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = col_ext[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_H_CMP: begin
				alu_b    = {2'b00, desc_q.dw, 1'b0};
				ram_we   = !alu_gt && !x_q[11];
				ram_addr = x_q[AW-1:0];
			end
			ST_H_ADD: begin
				alu_op = ALU_ADD;
				alu_b  = {2'b00, src_w_q, 1'b0};
			end
			ST_V_CMP: begin
				alu_a = vacc_q;
				alu_b = {2'b00, desc_q.dh, 1'b0};
			end
			ST_V_ADD: begin
				alu_op = ALU_ADD;
				alu_a  = vacc_q;
				alu_b  = {2'b00, src_h_q, 1'b0};
			end
			ST_RD: begin
				ram_re = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= 1'b0;
			mode_start_q <= 1'b0;
			kind_q       <= KIND_START_OK;
			out_valid_q  <= 1'b0;
			screen_w_q   <= 11'd640;
			screen_h_q   <= 11'd480;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				if (paddr[2]) begin
					screen_h_q <= pwdata[10:0];
				end else begin
					screen_w_q <= pwdata[10:0];
				end
			end
			if (in_fire) begin
				if (func == FUNC_START) begin
					busy_q <= 1'b0;
				end else begin
					kind_q <= busy_q ? KIND_PIXEL : KIND_IDLE_STEP;
				end
			end
			if (state_q == ST_CHECK) begin
				if (chk.reject) begin
					kind_q <= KIND_REJECT;
				end else begin
					mode_start_q <= 1'b1;
				end
			end
			if (state_q == ST_V_CMP && !alu_gt && v_done && mode_start_q) begin
				mode_start_q <= 1'b0;
				busy_q       <= 1'b1;
				kind_q       <= KIND_START_OK;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				if (kind_q == KIND_PIXEL && last_pix) begin
					busy_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && func == FUNC_START) begin
			desc_q.dx <= dest_x;
			desc_q.dy <= dest_y;
			desc_q.dw <= dest_w;
			desc_q.dh <= dest_h;
			desc_q.sl <= src_l;
			desc_q.st <= src_top;
			desc_q.sr <= src_r;
			desc_q.sb <= src_b;
			desc_q.bw <= bmp_w;
			desc_q.bh <= bmp_h;
		end
		unique case (state_q)
			ST_CHECK: begin
				clip_q  <= chk.clip;
				src_w_q <= chk.src_w;
				src_h_q <= chk.src_h;
				hacc_q  <= {3'b000, chk.src_w};
				px_q    <= desc_q.sl;
				x_q     <= desc_q.dx;
			end
			ST_H_CMP: begin
				if (alu_gt) begin
					hacc_q <= alu_res;
					px_q   <= px_q + 11'd1;
				end
			end
			ST_H_ADD: begin
				hacc_q <= alu_res;
				if (x_q == clip_q.right) begin
					vacc_q    <= {3'b000, src_h_q};
					src_row_q <= desc_q.st;
					cur_row_q <= desc_q.dy;
				end else begin
					x_q <= x_q + 12'sd1;
				end
			end
			ST_V_CMP: begin
				if (alu_gt) begin
					vacc_q    <= alu_res;
					src_row_q <= src_row_q + 11'd1;
				end else if (v_done && mode_start_q) begin
					cur_col_q <= clip_q.left[10:0];
				end
			end
			ST_V_ADD: begin
				vacc_q    <= alu_res;
				cur_row_q <= cur_row_q + 12'sd1;
			end
			ST_EMIT: begin
				if (emit_fire && kind_q == KIND_PIXEL && !last_pix) begin
					if (row_end) begin
						cur_col_q <= clip_q.left[10:0];
					end else begin
						cur_col_q <= cur_col_q + 11'd1;
					end
				end
			end
			default: begin
			end
		endcase
		if (emit_fire) begin
			kind <= kind_q;
			if (kind_q == KIND_PIXEL) begin
				out_dest_x <= cur_col_q[9:0];
				out_dest_y <= cur_row_q[9:0];
				out_src_x  <= ram_rdata;
				out_src_y  <= src_row_q[9:0];
				last       <= last_pix;
			end else begin
				out_dest_x <= '0;
				out_dest_y <= '0;
				out_src_x  <= '0;
				out_src_y  <= '0;
				last       <= 1'b0;
			end
		end
	end

	a_pixel_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && kind_q == KIND_PIXEL) |-> busy_q)
		else $error("Pixel transaction emitted while no blit is active.");

	a_no_negative_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !x_q[11])
		else $error("Column table written at an off-screen column.");

	a_clip_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (clip_q.left <= clip_q.right && clip_q.top <= clip_q.bottom))
		else $error("Active blit has an empty clip rectangle.");

	a_cursor_in_clip: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_col_q <= clip_q.right[10:0] && cur_row_q <= clip_q.bottom))
		else $error("Pixel cursor left the clip rectangle.");

	a_busy_rises_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> (state_q == ST_EMIT && kind_q == KIND_START_OK))
		else $error("Blit became active outside a start transaction.");

endmodule
`default_nettype wire
